[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

[src/pstc_pkg.sv]
// ----------------------------------------------------------------------------
// pstc_pkg
// Types, constants and calendar helpers of the pulse synced time calendar.
// ----------------------------------------------------------------------------
package pstc_pkg;

    localparam int YEAR_BITS = 12;

    localparam logic [5:0] SEC_LAST   = 6'd59;
    localparam logic [5:0] MIN_LAST   = 6'd59;
    localparam logic [4:0] HOUR_LAST  = 5'd23;
    localparam logic [3:0] FRAC_LAST  = 4'd9;
    localparam logic [3:0] MONTH_LAST = 4'd12;
    localparam logic [3:0] MONTH_FEB  = 4'd2;
    localparam int         YEAR_BASE  = 2000;

    // Divisibility by 25 through a multiply by ceil(2^24 / 25).
    localparam int DIV25_SHIFT = 24;
    localparam int DIV25_MAGIC = ((1 << DIV25_SHIFT) + 24) / 25;
    localparam int DIV25_BITS  = 20;

    localparam logic [4:0] MONTH_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic [1:0] {
        KIND_TICK       = 2'd0,
        KIND_PPS        = 2'd1,
        KIND_LOAD       = 2'd2,
        KIND_INVALIDATE = 2'd3
    } t_kind;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year_of_century;
        logic       status_active;
    } t_set;

    typedef struct packed {
        logic [4:0]           hour;
        logic [5:0]           minute;
        logic [5:0]           second;
        logic [3:0]           tenth;
        logic [3:0]           hundredth;
        logic [4:0]           day;
        logic [3:0]           month;
        logic [YEAR_BITS-1:0] year;
        logic                 time_valid;
        logic                 ever_loaded;
    } t_state;

    typedef struct packed {
        t_state state;
        logic   updated;
    } t_result;

    localparam t_state STATE_RESET = '{
        hour:        5'd0,
        minute:      6'd0,
        second:      6'd0,
        tenth:       4'd0,
        hundredth:   4'd0,
        day:         5'd1,
        month:       4'd1,
        year:        YEAR_BITS'(YEAR_BASE),
        time_valid:  1'b0,
        ever_loaded: 1'b0
    };

    function automatic logic is_leap(input logic [YEAR_BITS-1:0] year);
        logic [YEAR_BITS+DIV25_BITS-1:0] prod;
        logic                            div25;
        prod  = (YEAR_BITS+DIV25_BITS)'(year) * (YEAR_BITS+DIV25_BITS)'(DIV25_MAGIC);
        div25 = (prod[DIV25_SHIFT-1:0] < DIV25_SHIFT'(DIV25_MAGIC));
        return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] month,
                                                input logic       leap);
        logic [4:0] len;
        len = 5'd31;
        if ((month != 4'd0) && (month <= MONTH_LAST)) begin
            len = MONTH_DAYS[month - 4'd1];
            if ((month == MONTH_FEB) && leap) begin
                len = len + 5'd1;
            end
        end
        return len;
    endfunction

endpackage

[src/pps_synced_time_calendar.sv]
// ----------------------------------------------------------------------------
// pps_synced_time_calendar: events pass an input and a result register.
// One event per cycle unless the sink stalls; one register step updates state.
// Synchronous active-low reset clears both stages and sets 2000-01-01 00:00.
// ----------------------------------------------------------------------------
module pps_synced_time_calendar
    import pstc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: set_hour, set_minute, set_second, set_day, set_month,
    // set_year_of_century, set_status_active, zero fill.
    input  logic [39:0] s_axis_tdata,
    // tuser: kind.
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: hour, minute, second, tenth, hundredth, day, month, year,
    // time_valid, ever_loaded, updated, zero fill.
    output logic [55:0] m_axis_tdata
);

    t_set    in_set;
    t_set    stage_set;
    t_kind   stage_kind;
    logic    stage_valid;
    logic    out_valid;
    logic    step;
    t_result core_result;
    t_result out_result;

    assign in_set.hour            = s_axis_tdata[4:0];
    assign in_set.minute          = s_axis_tdata[10:5];
    assign in_set.second          = s_axis_tdata[16:11];
    assign in_set.day             = s_axis_tdata[21:17];
    assign in_set.month           = s_axis_tdata[25:22];
    assign in_set.year_of_century = s_axis_tdata[32:26];
    assign in_set.status_active   = s_axis_tdata[33];

    assign step = stage_valid && (!out_valid || m_axis_tready);

    pstc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_kind  (t_kind'(s_axis_tuser)),
        .i_set   (in_set),
        .i_take  (step),
        .o_valid (stage_valid),
        .o_kind  (stage_kind),
        .o_set   (stage_set)
    );

    pstc_clock_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_kind   (stage_kind),
        .i_set    (stage_set),
        .o_result (core_result)
    );

    pstc_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (core_result),
        .i_ready  (m_axis_tready),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {
        7'd0,
        out_result.updated,
        out_result.state.ever_loaded,
        out_result.state.time_valid,
        out_result.state.year,
        out_result.state.month,
        out_result.state.day,
        out_result.state.hundredth,
        out_result.state.tenth,
        out_result.state.second,
        out_result.state.minute,
        out_result.state.hour
    };

endmodule

[src/pstc_in_stage.sv]
// ----------------------------------------------------------------------------
// pstc_in_stage
// Input register that holds one event until the update logic takes it.
// ----------------------------------------------------------------------------
module pstc_in_stage
    import pstc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_kind i_kind,
    input  t_set  i_set,
    input  logic  i_take,
    output logic  o_valid,
    output t_kind o_kind,
    output t_set  o_set
);

    logic  r_valid;
    t_kind r_kind;
    t_set  r_set;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_kind <= i_kind;
            r_set  <= i_set;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_set   = r_set;

endmodule

[src/pstc_clock_core.sv]
// ----------------------------------------------------------------------------
// pstc_clock_core
// Time and date registers with the tick, pulse, load and invalidate update.
// ----------------------------------------------------------------------------
module pstc_clock_core
    import pstc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_kind   i_kind,
    input  t_set    i_set,
    output t_result o_result
);

    t_state r_state;
    t_state n_state;
    logic   n_updated;
    logic   leap;
    logic   month_end;

    assign leap      = is_leap(r_state.year);
    assign month_end = (r_state.day >= month_length(r_state.month, leap));

    always_comb begin
        n_state   = r_state;
        n_updated = 1'b0;
        unique case (i_kind)
            KIND_TICK: begin
                if (r_state.hundredth >= FRAC_LAST) begin
                    n_state.hundredth = 4'd0;
                    if (r_state.tenth < FRAC_LAST) begin
                        n_state.tenth = r_state.tenth + 4'd1;
                        n_updated     = 1'b1;
                    end
                end else begin
                    n_state.hundredth = r_state.hundredth + 4'd1;
                    n_updated         = 1'b1;
                end
            end
            KIND_PPS: begin
                n_state.hundredth = 4'd0;
                n_state.tenth     = 4'd0;
                n_updated         = 1'b1;
                if (r_state.second < SEC_LAST) begin
                    n_state.second = r_state.second + 6'd1;
                end else begin
                    n_state.second = 6'd0;
                    if (r_state.minute < MIN_LAST) begin
                        n_state.minute = r_state.minute + 6'd1;
                    end else begin
                        n_state.minute = 6'd0;
                        if (r_state.hour < HOUR_LAST) begin
                            n_state.hour = r_state.hour + 5'd1;
                        end else begin
                            n_state.hour = 5'd0;
                            if (month_end) begin
                                n_state.day = 5'd1;
                                if (r_state.month >= MONTH_LAST) begin
                                    n_state.month = 4'd1;
                                    n_state.year  = r_state.year + YEAR_BITS'(1);
                                end else begin
                                    n_state.month = r_state.month + 4'd1;
                                end
                            end else begin
                                n_state.day = r_state.day + 5'd1;
                            end
                        end
                    end
                end
            end
            KIND_LOAD: begin
                n_state.hour        = i_set.hour;
                n_state.minute      = i_set.minute;
                n_state.second      = i_set.second;
                n_state.day         = i_set.day;
                n_state.month       = i_set.month;
                n_state.year        = YEAR_BITS'(YEAR_BASE)
                                    + YEAR_BITS'(i_set.year_of_century);
                n_state.time_valid  = i_set.status_active;
                n_state.ever_loaded = 1'b1;
            end
            KIND_INVALIDATE: begin
                n_state.time_valid = 1'b0;
            end
            default: begin
                n_state = r_state;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    assign o_result.state   = n_state;
    assign o_result.updated = n_updated;

endmodule

[src/pstc_out_stage.sv]
// ----------------------------------------------------------------------------
// pstc_out_stage
// Result register that holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module pstc_out_stage
    import pstc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[src/pstc_checker.sv]
// ----------------------------------------------------------------------------
// pstc_checker
// Port-level checks of the result stream of the time calendar.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pstc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [55:0] i_m_tdata
);

    `ASSERT_CLK(a_stall_hold, i_m_tvalid && !i_m_tready |=> $stable(i_m_tdata), "result changed while stalled")
    `ASSERT_CLK_ALWAYS(a_reset_empty, !i_rst_n |=> !i_m_tvalid, "result valid after reset")
    `ASSERT_CLK(a_frac_range, i_m_tvalid |-> (i_m_tdata[20:17] <= 4'd9) && (i_m_tdata[24:21] <= 4'd9), "fraction out of range")
    `ASSERT_CLK(a_valid_hold, i_m_tvalid && !i_m_tready |=> i_m_tvalid, "result dropped while stalled")

endmodule

bind pps_synced_time_calendar pstc_checker u_pstc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

[tb/sv/tb_pps_synced_time_calendar.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pps_synced_time_calendar
// Self-checking testbench for the pulse synced time calendar. A directed set
// of loads and pulses walks the date rollovers, leap years and out of range
// loads, then random scenarios of ticks, pulses, loads and invalidates run
// with random gaps and stalls on both streams. Every result is checked field
// by field against a behavioral calendar kept inside the testbench.
// ----------------------------------------------------------------------------
module tb_pps_synced_time_calendar;
    import pstc_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int EVENT_TARGET = 1950;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_WAIT  = 10;

    localparam int DAYS_PER_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct {
        t_kind      kind;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year_of_century;
        logic       active;
        int         gap;
        bit         drain;
    } t_clock_event;

    typedef struct {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [3:0]  tenth;
        logic [3:0]  hundredth;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic        time_valid;
        logic        ever_loaded;
        logic        updated;
        logic [6:0]  fill;
    } t_calendar;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata: set_hour, set_minute, set_second, set_day, set_month,
    // set_year_of_century, set_status_active, zero fill.
    logic [39:0] s_axis_tdata  = '0;
    // tuser: kind.
    logic [1:0]  s_axis_tuser  = KIND_TICK;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata: hour, minute, second, tenth, hundredth, day, month, year,
    // time_valid, ever_loaded, updated, zero fill.
    logic [55:0] m_axis_tdata;

    t_clock_event pending_events [$];
    t_calendar    expected_times [$];
    t_calendar    calendar;

    int  total_events;
    int  events_taken;
    int  times_checked;
    int  errors;
    int  cycle_count;
    int  kind_seen [4];
    int  held_ticks;
    int  src_gap;
    int  src_calm;
    int  rx_wait;
    int  rx_calm;
    int  rx_long;
    int  long_holds;
    bit  in_taken;
    bit  out_taken;

    pps_synced_time_calendar dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic int draw_gap();
        if (src_calm > 0) begin
            src_calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            src_calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    function automatic void push_load(input int hour, input int minute, input int second,
                                      input int day, input int month, input int yoc,
                                      input int active);
        t_clock_event ev;
        ev.kind            = KIND_LOAD;
        ev.hour            = 5'(hour);
        ev.minute          = 6'(minute);
        ev.second          = 6'(second);
        ev.day             = 5'(day);
        ev.month           = 4'(month);
        ev.year_of_century = 7'(yoc);
        ev.active          = 1'(active);
        ev.gap             = draw_gap();
        ev.drain           = 1'b0;
        pending_events.push_back(ev);
    endfunction

    // Loads carry random fields in full width; other kinds carry random but
    // ignored fields.
    function automatic void push_random(input t_kind kind);
        push_load($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        pending_events[$].kind = kind;
    endfunction

    // A load placed just ahead of a rollover, with month and day around the
    // month ends and now and then out of range.
    function automatic void push_edge_load();
        int month;
        case ($urandom_range(0, 2))
            0: month = MONTH_LAST;
            1: month = MONTH_FEB;
            default: month = $urandom_range(0, 15);
        endcase
        push_load(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : HOUR_LAST,
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : MIN_LAST,
                  $urandom_range(55, 63), $urandom_range(26, 31), month,
                  $urandom_range(0, 127), $urandom_range(0, 1));
    endfunction

    function automatic t_calendar next_calendar(input t_calendar now, input t_kind kind,
                                                input logic [39:0] data);
        t_calendar c;
        int        month_days;
        int        y;
        c         = now;
        c.updated = 1'b0;
        case (kind)
            KIND_TICK: begin
                if (c.hundredth >= FRAC_LAST) begin
                    c.hundredth = 4'd0;
                    if (c.tenth < FRAC_LAST) begin
                        c.tenth   = c.tenth + 4'd1;
                        c.updated = 1'b1;
                    end
                end else begin
                    c.hundredth = c.hundredth + 4'd1;
                    c.updated   = 1'b1;
                end
            end
            KIND_PPS: begin
                c.hundredth = 4'd0;
                c.tenth     = 4'd0;
                c.updated   = 1'b1;
                if (c.second < SEC_LAST) begin
                    c.second = c.second + 6'd1;
                end else begin
                    c.second = 6'd0;
                    if (c.minute < MIN_LAST) begin
                        c.minute = c.minute + 6'd1;
                    end else begin
                        c.minute = 6'd0;
                        if (c.hour < HOUR_LAST) begin
                            c.hour = c.hour + 5'd1;
                        end else begin
                            c.hour     = 5'd0;
                            y          = int'(c.year);
                            month_days = 31;
                            if (c.month >= 4'd1 && c.month <= MONTH_LAST) begin
                                month_days = DAYS_PER_MONTH[c.month - 1];
                                if (c.month == MONTH_FEB &&
                                    (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0))) begin
                                    month_days++;
                                end
                            end
                            if (int'(c.day) >= month_days) begin
                                c.day = 5'd1;
                                if (c.month >= MONTH_LAST) begin
                                    c.month = 4'd1;
                                    c.year  = c.year + 12'd1;
                                end else begin
                                    c.month = c.month + 4'd1;
                                end
                            end else begin
                                c.day = c.day + 5'd1;
                            end
                        end
                    end
                end
            end
            KIND_LOAD: begin
                c.hour        = data[4:0];
                c.minute      = data[10:5];
                c.second      = data[16:11];
                c.day         = data[21:17];
                c.month       = data[25:22];
                c.year        = 12'(YEAR_BASE + int'(data[32:26]));
                c.time_valid  = data[33];
                c.ever_loaded = 1'b1;
            end
            default: begin
                c.time_valid = 1'b0;
            end
        endcase
        return c;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: time %0d field %s expected %0d actual %0d",
                     $time, times_checked, name, want, got);
        end
    endfunction

    // Prediction and checking, both at the rising edge.
    always @(posedge i_clk) begin : observe
        t_calendar want;
        t_calendar got;
        cycle_count++;
        if (!i_rst_n) begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end else begin
            in_taken  <= s_axis_tvalid && s_axis_tready;
            out_taken <= m_axis_tvalid && m_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                calendar = next_calendar(calendar, t_kind'(s_axis_tuser), s_axis_tdata);
                expected_times.push_back(calendar);
                events_taken++;
                kind_seen[s_axis_tuser]++;
                if (s_axis_tuser == KIND_TICK && !calendar.updated) begin
                    held_ticks++;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_times.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transaction, expected none actual %h",
                             $time, m_axis_tdata);
                end else begin
                    want      = expected_times.pop_front();
                    want.fill = 7'd0;
                    got.hour        = m_axis_tdata[4:0];
                    got.minute      = m_axis_tdata[10:5];
                    got.second      = m_axis_tdata[16:11];
                    got.tenth       = m_axis_tdata[20:17];
                    got.hundredth   = m_axis_tdata[24:21];
                    got.day         = m_axis_tdata[29:25];
                    got.month       = m_axis_tdata[33:30];
                    got.year        = m_axis_tdata[45:34];
                    got.time_valid  = m_axis_tdata[46];
                    got.ever_loaded = m_axis_tdata[47];
                    got.updated     = m_axis_tdata[48];
                    got.fill        = m_axis_tdata[55:49];
                    check_field("hour", want.hour, got.hour);
                    check_field("minute", want.minute, got.minute);
                    check_field("second", want.second, got.second);
                    check_field("tenth", want.tenth, got.tenth);
                    check_field("hundredth", want.hundredth, got.hundredth);
                    check_field("day", want.day, got.day);
                    check_field("month", want.month, got.month);
                    check_field("year", want.year, got.year);
                    check_field("time_valid", want.time_valid, got.time_valid);
                    check_field("ever_loaded", want.ever_loaded, got.ever_loaded);
                    check_field("updated", want.updated, got.updated);
                    check_field("fill", want.fill, got.fill);
                    times_checked++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d of %0d events taken",
                     $time, cycle_count, events_taken, total_events);
            $display("tb_pps_synced_time_calendar: FAIL");
            $finish;
        end
    end

    // Event source: a drain mark holds the next event until all times are back.
    always @(negedge i_clk) begin : source_drive
        t_clock_event ev;
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_events.size() != 0 &&
                         !(pending_events[0].drain && expected_times.size() != 0)) begin
                ev = pending_events.pop_front();
                s_axis_tuser  <= ev.kind;
                s_axis_tdata  <= {6'd0, ev.active, ev.year_of_century, ev.month, ev.day,
                                  ev.second, ev.minute, ev.hour};
                s_axis_tvalid <= 1'b1;
                src_gap = ev.gap;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Time sink: random stalls per transaction and two long hold-offs.
    always @(negedge i_clk) begin : sink_drive
        if (i_rst_n) begin
            if (out_taken) begin
                if (rx_calm > 0) begin
                    rx_calm--;
                    rx_wait = 0;
                end else if ($urandom_range(0, 19) == 0) begin
                    rx_calm = $urandom_range(20, 50);
                    rx_wait = 0;
                end else begin
                    rx_wait = $urandom_range(0, 4);
                end
            end
            if ((long_holds == 0 && times_checked >= 400) ||
                (long_holds == 1 && times_checked >= 1300)) begin
                long_holds++;
                rx_long = 300;
            end
            if (rx_long > 0) begin
                rx_long--;
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int scenario;
        int count;
        calendar = '{hour: 5'd0, minute: 6'd0, second: 6'd0, tenth: 4'd0,
                     hundredth: 4'd0, day: 5'd1, month: 4'd1, year: 12'(YEAR_BASE),
                     time_valid: 1'b0, ever_loaded: 1'b0, updated: 1'b0, fill: 7'd0};

        // Directed: reset state, all-zero and all-one loads, rollovers of
        // every unit from second to year, leap and common Februaries, out of range months.
        push_random(KIND_TICK);
        push_random(KIND_INVALIDATE);
        push_random(KIND_PPS);
        push_load(0, 0, 0, 0, 0, 0, 0);
        push_random(KIND_PPS);
        push_load(23, 59, 59, 31, 0, 0, 1);
        push_random(KIND_PPS);
        push_load(31, 63, 63, 31, 15, 127, 1);
        push_random(KIND_PPS);
        push_load(23, 59, 59, 31, 12, 99, 1);
        push_random(KIND_PPS);
        push_load(23, 59, 59, 28, 2, 0, 1);
        push_random(KIND_PPS);
        push_load(23, 59, 59, 28, 2, 1, 0);
        push_random(KIND_PPS);
        push_load(23, 59, 59, 29, 2, 4, 1);
        push_random(KIND_PPS);
        push_load(23, 59, 59, 30, 4, 50, 1);
        push_random(KIND_PPS);
        push_load(23, 59, 58, 31, 13, 20, 1);
        push_random(KIND_PPS);
        push_random(KIND_PPS);
        push_random(KIND_INVALIDATE);
        push_random(KIND_TICK);
        push_random(KIND_TICK);

        while (pending_events.size() < EVENT_TARGET) begin
            scenario = $urandom_range(0, 9);
            if (scenario <= 3) begin
                push_random(KIND_PPS);
                count = $urandom_range(0, 12);
                repeat (count) push_random(KIND_TICK);
            end else if (scenario == 4) begin
                count = $urandom_range(90, 110);
                repeat (count) push_random(KIND_TICK);
                push_random(KIND_PPS);
            end else if (scenario <= 6) begin
                push_edge_load();
                count = $urandom_range(1, 8);
                repeat (count) begin
                    push_random(KIND_PPS);
                    repeat ($urandom_range(0, 3)) push_random(KIND_TICK);
                end
            end else if (scenario == 7) begin
                push_random(KIND_LOAD);
            end else if (scenario == 8) begin
                push_random(KIND_INVALIDATE);
            end else begin
                count = $urandom_range(1, 6);
                repeat (count) push_random(t_kind'($urandom_range(0, 3)));
            end
        end
        pending_events[600].drain  = 1'b1;
        pending_events[1400].drain = 1'b1;
        total_events = pending_events.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (events_taken != total_events || expected_times.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_WAIT) @(posedge i_clk);

        $display("Checked %0d times from %0d events: %0d ticks, %0d pulses, %0d loads,",
                 times_checked, events_taken, kind_seen[KIND_TICK], kind_seen[KIND_PPS],
                 kind_seen[KIND_LOAD]);
        $display("%0d invalidates, %0d ticks held at the last tenth, %0d errors.",
                 kind_seen[KIND_INVALIDATE], held_ticks, errors);
        if (errors == 0) begin
            $display("tb_pps_synced_time_calendar: PASS");
        end else begin
            $display("tb_pps_synced_time_calendar: FAIL");
        end
        $finish;
    end

endmodule
